// ----- sv/assert_macros.svh -----
// Assertion macros for the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define ASSERT_RST(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Clocked assertion that also holds across reset.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// ----- sv/asa_pkg.sv -----
// Types and constants shared by the aligned stack allocator.
package asa_pkg;

  localparam int ADDR_W      = 32;
  localparam int SIZE_W      = 21;
  localparam int ALIGN_W     = 4;
  localparam int ALIGN_C_W   = 5;
  localparam int OFS_W       = 23;
  localparam int CFG_IDX_W   = 8;

  typedef enum logic [1:0] {
    K_ALLOC = 2'd0,
    K_FREE  = 2'd1,
    K_QUERY = 2'd2,
    K_RESET = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NO_SPACE = 3'd1,
    ST_NOT_TOP  = 3'd2,
    ST_FULL     = 3'd3,
    ST_NULL     = 3'd4
  } status_t;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY     = 8'd1;

  localparam logic [ADDR_W-1:0] BASE_RESET     = 32'd4096;
  localparam logic [SIZE_W-1:0] CAPACITY_RESET = 21'd65536;

  // Input transaction payload.
  typedef struct packed {
    kind_t               kind;
    logic [SIZE_W-1:0]   request_size;
    logic [ALIGN_W-1:0]  align_log2;
    logic [ADDR_W-1:0]   address;
  } cmd_req_t;

  // Result transaction payload.
  typedef struct packed {
    status_t             status;
    logic [ADDR_W-1:0]   block_address;
    logic [SIZE_W-1:0]   allocated_size;
    logic [SIZE_W-1:0]   used_bytes;
  } rsp_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [ADDR_W-1:0]    value;
  } cfg_wr_t;

  // Classified command as held in the queue.
  typedef struct packed {
    kind_t                kind;
    logic                 is_null;
    logic [SIZE_W-1:0]    request_size;
    logic [ALIGN_C_W-1:0] align;
    logic [ADDR_W-1:0]    address;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC_PAD,
    S_ALLOC_CHK,
    S_FREE_CHK,
    S_QUERY,
    S_DONE
  } back_state_t;

endpackage

// ----- sv/asa_stream_if.sv -----
// Valid/ready channel carrying one payload type.
interface asa_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/asa_front.sv -----
// Front end: accepts commands, clamps alignment, flags null addresses.
module asa_front import asa_pkg::*; #(
  parameter int MAX_ALIGN_LOG2 = 12
) (
  input  logic      in_valid,
  output logic      in_ready,
  input  cmd_req_t  in_data,
  input  q_status_t q_stat,
  output logic      push,
  output cmd_t      push_data
);

  localparam logic [ALIGN_C_W-1:0] ALIGN_MAX = ALIGN_C_W'(MAX_ALIGN_LOG2);

  logic [ALIGN_C_W-1:0] align_in;

  assign in_ready = !q_stat.full;
  assign push     = in_valid && in_ready;
  assign align_in = ALIGN_C_W'(in_data.align_log2);

  always_comb begin
    push_data.kind         = in_data.kind;
    push_data.is_null      = (in_data.address == '0);
    push_data.request_size = in_data.request_size;
    push_data.align        = (align_in > ALIGN_MAX) ? ALIGN_MAX : align_in;
    push_data.address      = in_data.address;
  end

endmodule

// ----- sv/asa_cmd_queue.sv -----
// Two-entry command queue between front and back.
module asa_cmd_queue import asa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  cmd_t      push_data,
  input  logic      pop,
  output cmd_t      pop_data,
  output q_status_t stat
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] level;

  assign pop_data   = entries[rd_ptr];
  assign stat.valid = (level != '0);
  assign stat.full  = (level == CNT_W'(DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      level <= level + 1'b1;
      else if (pop && !push) level <= level - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

endmodule

// ----- sv/asa_back.sv -----
// Back end: arena state, block record store and result register.
module asa_back import asa_pkg::*; #(
  parameter int HEADER_BYTES   = 16,
  parameter int MAX_BLOCKS     = 16,
  parameter int MAX_ALIGN_LOG2 = 12
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  cfg_wr_t   cfg_wr,
  input  q_status_t q_stat,
  input  cmd_t      q_data,
  output logic      q_pop,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output rsp_t      rsp_data
);

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int PAD_W = (MAX_ALIGN_LOG2 > 0) ? MAX_ALIGN_LOG2 : 1;

  typedef struct packed {
    logic [SIZE_W-1:0] start;
    logic [SIZE_W-1:0] size;
    logic [OFS_W-1:0]  boff;   // offset of the block address from base
  } rec_t;

  back_state_t state, state_next;

  logic [ADDR_W-1:0] base_address;
  logic [SIZE_W-1:0] capacity;
  logic [SIZE_W-1:0] used_offset, used_next;
  logic [CNT_W-1:0]  block_count, count_next;
  logic              used_we, count_we;

  rec_t              rec_mem [MAX_BLOCKS];
  rec_t              rd_data;
  rec_t              wr_rec;
  logic [IDX_W-1:0]  rd_addr;
  logic              mem_we;

  cmd_t              cur;
  logic              cur_we;
  logic [ADDR_W:0]   newb;
  logic [OFS_W-1:0]  hdr_end;
  logic [PAD_W-1:0]  pad, pad_c;
  logic [ADDR_W+1:0] aligned_c;
  logic [OFS_W-1:0]  boff_c, end_c;

  logic [IDX_W-1:0]  scan_idx;
  logic [CNT_W-1:0]  issue_left;
  logic              chk_valid, scan_step;

  status_t           res_status, res_status_c;
  logic [ADDR_W-1:0] res_blk, res_blk_c;
  logic [SIZE_W-1:0] res_size, res_size_c;
  logic              res_we, load_out;

  logic              cnt_full, cnt_zero, alloc_fail, rec_match, scan_miss;
  logic [IDX_W-1:0]  cnt_m1;
  logic [CNT_W-1:0]  cnt_dec;

  assign cnt_full  = (block_count >= CNT_W'(MAX_BLOCKS));
  assign cnt_zero  = (block_count == '0);
  assign cnt_dec   = block_count - 1'b1;
  assign cnt_m1    = cnt_dec[IDX_W-1:0];

  // Padding up to the requested power of two, from the low bits only.
  assign pad_c     = (~newb[PAD_W-1:0] + 1'b1) & ~({PAD_W{1'b1}} << cur.align);
  assign aligned_c = {1'b0, newb} + (ADDR_W+2)'(pad);
  assign boff_c    = hdr_end + OFS_W'(pad);
  assign end_c     = boff_c + OFS_W'(cur.request_size);
  assign alloc_fail = (end_c > OFS_W'(capacity)) || (aligned_c[ADDR_W+1:ADDR_W] != '0);

  assign rec_match = ((ADDR_W+1)'(base_address) + (ADDR_W+1)'(rd_data.boff))
                     == (ADDR_W+1)'(cur.address);
  assign scan_miss = !chk_valid && (issue_left == '0);
  assign scan_step = (state == S_QUERY) && (issue_left != '0);
  assign load_out  = (state == S_DONE) && (!rsp_valid || rsp_ready);

  assign wr_rec.start = used_offset;
  assign wr_rec.size  = cur.request_size;
  assign wr_rec.boff  = boff_c;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (q_stat.valid) begin
          unique case (q_data.kind)
            K_ALLOC: state_next = cnt_full ? S_DONE : S_ALLOC_PAD;
            K_FREE:  state_next = (q_data.is_null || cnt_zero) ? S_DONE : S_FREE_CHK;
            K_QUERY: state_next = (q_data.is_null || cnt_zero) ? S_DONE : S_QUERY;
            K_RESET: state_next = S_DONE;
          endcase
        end
      end
      S_ALLOC_PAD: state_next = S_ALLOC_CHK;
      S_ALLOC_CHK: state_next = S_DONE;
      S_FREE_CHK:  state_next = S_DONE;
      S_QUERY: begin
        if ((chk_valid && rec_match) || scan_miss) state_next = S_DONE;
      end
      S_DONE: begin
        if (!rsp_valid || rsp_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control and datapath selects
  always_comb begin
    q_pop        = 1'b0;
    cur_we       = 1'b0;
    rd_addr      = cnt_m1;
    mem_we       = 1'b0;
    used_we      = 1'b0;
    used_next    = used_offset;
    count_we     = 1'b0;
    count_next   = block_count;
    res_we       = 1'b0;
    res_status_c = ST_OK;
    res_blk_c    = '0;
    res_size_c   = '0;
    unique case (state)
      S_IDLE: begin
        if (q_stat.valid) begin
          q_pop  = 1'b1;
          cur_we = 1'b1;
          res_we = 1'b1;
          unique case (q_data.kind)
            K_ALLOC: if (cnt_full) res_status_c = ST_FULL;
            K_FREE: begin
              if (q_data.is_null) res_status_c = ST_NULL;
              else if (cnt_zero)  res_status_c = ST_NOT_TOP;
            end
            K_QUERY: if (q_data.is_null) res_status_c = ST_NULL;
            K_RESET: begin
              used_we    = 1'b1;
              used_next  = '0;
              count_we   = 1'b1;
              count_next = '0;
            end
          endcase
        end
      end
      S_ALLOC_PAD: ;
      S_ALLOC_CHK: begin
        res_we = 1'b1;
        if (alloc_fail) begin
          res_status_c = ST_NO_SPACE;
        end else begin
          mem_we     = 1'b1;
          count_we   = 1'b1;
          count_next = block_count + 1'b1;
          used_we    = 1'b1;
          used_next  = end_c[SIZE_W-1:0];
          res_blk_c  = aligned_c[ADDR_W-1:0];
        end
      end
      S_FREE_CHK: begin
        res_we = 1'b1;
        if (rec_match) begin
          count_we   = 1'b1;
          count_next = cnt_dec;
          used_we    = 1'b1;
          used_next  = rd_data.start;
        end else begin
          res_status_c = ST_NOT_TOP;
        end
      end
      S_QUERY: begin
        rd_addr = scan_idx;
        if (chk_valid && rec_match) begin
          res_we     = 1'b1;
          res_size_c = rd_data.size;
        end else if (scan_miss) begin
          res_we = 1'b1;
        end
      end
      S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      base_address <= BASE_RESET;
      capacity     <= CAPACITY_RESET;
      used_offset  <= '0;
      block_count  <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        priority if (cfg_wr.index == CFG_BASE_ADDRESS) begin
          base_address <= cfg_wr.value;
        end else if (cfg_wr.index == CFG_CAPACITY) begin
          capacity <= cfg_wr.value[SIZE_W-1:0];
        end
      end
      if (used_we)  used_offset <= used_next;
      if (count_we) block_count <= count_next;
      if (load_out)       rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

  // Record store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) rec_mem[block_count[IDX_W-1:0]] <= wr_rec;
    rd_data <= rec_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    pad       <= pad_c;
    chk_valid <= scan_step;
    if (cur_we) begin
      cur        <= q_data;
      newb       <= (ADDR_W+1)'(base_address) + (ADDR_W+1)'(used_offset)
                    + (ADDR_W+1)'(HEADER_BYTES);
      hdr_end    <= OFS_W'(used_offset) + OFS_W'(HEADER_BYTES);
      scan_idx   <= cnt_m1;
      issue_left <= block_count;
    end else if (scan_step) begin
      scan_idx   <= scan_idx - 1'b1;
      issue_left <= issue_left - 1'b1;
    end
    if (res_we) begin
      res_status <= res_status_c;
      res_blk    <= res_blk_c;
      res_size   <= res_size_c;
    end
    if (load_out) begin
      rsp_data.status         <= res_status;
      rsp_data.block_address  <= res_blk;
      rsp_data.allocated_size <= res_size;
      rsp_data.used_bytes     <= used_offset;
    end
  end

endmodule

// ----- sv/aligned_stack_allocator.sv -----
// LIFO arena allocator with aligned blocks and a record stack.
// Channels: cmd takes one operation per transaction (allocate, free, query,
// reset); rsp returns one result transaction per command, in order; cfg
// writes base_address (index 0) and capacity (index 1) and is always ready.
// Commands pass a classifying front end into a two-entry queue; the back end
// works one command at a time. From the queue, allocate passes S_ALLOC_PAD
// and S_ALLOC_CHK, free passes S_FREE_CHK, a query scans in S_QUERY until a
// hit or past every live block (the record store is read one entry a cycle,
// top first), and reset, null or empty-stack free or query, and allocate on a
// full record stack go straight to S_DONE, which moves the result register
// into the output register and raises rsp.valid. Commands are popped only
// in S_IDLE. When rsp is stalled the finished result waits in the output
// register and the back end holds; the queue keeps taking commands until
// it is full. Reset empties the queue and the output register, clears the
// offset and block count and loads the configuration defaults. The record
// store needs no clearing: only entries below the block count are read.
`include "assert_macros.svh"

module aligned_stack_allocator import asa_pkg::*; #(
  parameter int HEADER_BYTES   = 16,
  parameter int MAX_BLOCKS     = 16,
  parameter int MAX_ALIGN_LOG2 = 12
) (
  input logic          clk,
  input logic          rst,
  asa_stream_if.sink   cmd,
  asa_stream_if.source rsp,
  asa_stream_if.sink   cfg
);

  q_status_t q_stat;
  logic      push, q_pop;
  cmd_t      push_data, q_data;
  cfg_wr_t   cfg_wr;
  logic      rsp_no_space;

  assign cfg.ready    = 1'b1;
  assign cfg_wr       = cfg.data;
  assign rsp_no_space = rsp.valid && (rsp.data.status == ST_NO_SPACE);

  asa_front #(
    .MAX_ALIGN_LOG2 (MAX_ALIGN_LOG2)
  ) u_front (
    .in_valid  (cmd.valid),
    .in_ready  (cmd.ready),
    .in_data   (cmd.data),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  asa_cmd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (q_pop),
    .pop_data  (q_data),
    .stat      (q_stat)
  );

  asa_back #(
    .HEADER_BYTES   (HEADER_BYTES),
    .MAX_BLOCKS     (MAX_BLOCKS),
    .MAX_ALIGN_LOG2 (MAX_ALIGN_LOG2)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg.valid),
    .cfg_wr    (cfg_wr),
    .q_stat    (q_stat),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
  );

  `ASSERT_ALWAYS(a_reset_empties, clk, rst |=> !rsp.valid && !q_stat.valid)
  `ASSERT_RST(a_pop_spaced, clk, rst, q_pop |=> !q_pop)
  `ASSERT_RST(a_full_blocks_cmd, clk, rst, q_stat.full |-> !cmd.ready)
  `ASSERT_RST(a_no_space_null, clk, rst, rsp_no_space |-> rsp.data.block_address == '0)

endmodule

// ----- tb/asa_arena_checker.sv -----
// Checker for the aligned stack allocator: mirrors the arena and compares every result.
module asa_arena_checker import asa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  logic              cmd_ready,
  input  cmd_req_t          cmd_data,
  input  logic              rsp_valid,
  input  logic              rsp_ready,
  input  rsp_t              rsp_data,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  cfg_wr_t           cfg_data,
  output int                fails,
  output int                pending,
  output int                live_count,
  output logic [15:0][31:0] live_addr
);

  localparam int HDR       = 16;
  localparam int DEPTH     = 16;
  localparam int ALIGN_MAX = 12;

  logic [31:0] arena_base;
  logic [20:0] arena_cap;
  logic [20:0] offset;
  int          nblocks;
  logic [20:0] blk_start [DEPTH];
  logic [20:0] blk_size  [DEPTH];
  logic [31:0] blk_pad   [DEPTH];
  rsp_t        outcomes  [$];

  // Address handed out for a live block; follows the current base.
  function automatic logic [63:0] block_addr(int i);
    return 64'(arena_base) + 64'(blk_start[i]) + 64'(HDR) + 64'(blk_pad[i]);
  endfunction

  function automatic rsp_t apply_arena_op(cmd_req_t c);
    rsp_t        r;
    logic [3:0]  lg;
    logic [63:0] align;
    logic [63:0] raw;
    logic [63:0] aligned;
    logic [63:0] pad;
    logic [63:0] total;
    int          i;
    r = '0;
    r.status = ST_OK;
    case (c.kind)
      K_ALLOC: begin
        // record limit is checked ahead of space
        if (nblocks >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          lg = (c.align_log2 > ALIGN_MAX) ? 4'(ALIGN_MAX) : c.align_log2;
          align = 64'd1 << lg;
          raw = 64'(arena_base) + 64'(offset) + 64'(HDR);
          aligned = (raw + align - 64'd1) & ~(align - 64'd1);
          pad = aligned - raw;
          total = 64'(HDR) + pad + 64'(c.request_size);
          if (64'(offset) + total > 64'(arena_cap) || aligned > 64'hFFFF_FFFF) begin
            r.status = ST_NO_SPACE;
          end else begin
            blk_start[nblocks] = offset;
            blk_size[nblocks] = c.request_size;
            blk_pad[nblocks] = 32'(pad);
            nblocks++;
            offset = 21'(64'(offset) + total);
            r.block_address = 32'(aligned);
          end
        end
      end
      K_FREE: begin
        if (c.address == '0) begin
          r.status = ST_NULL;
        end else if (nblocks > 0 && block_addr(nblocks - 1) == 64'(c.address)) begin
          nblocks--;
          offset = blk_start[nblocks];
        end else begin
          r.status = ST_NOT_TOP;
        end
      end
      K_QUERY: begin
        if (c.address == '0) begin
          r.status = ST_NULL;
        end else begin
          i = nblocks - 1;
          while (i >= 0) begin
            if (block_addr(i) == 64'(c.address)) begin
              r.allocated_size = blk_size[i];
              i = -1;
            end else begin
              i--;
            end
          end
        end
      end
      default: begin
        offset = '0;
        nblocks = 0;
      end
    endcase
    r.used_bytes = offset;
    return r;
  endfunction

  task automatic report(input string msg);
    $display("ERROR: %s", msg);
    fails++;
  endtask

  always @(posedge clk) begin : watch
    rsp_t want;
    if (rst) begin
      arena_base = BASE_RESET;
      arena_cap = CAPACITY_RESET;
      offset = '0;
      nblocks = 0;
      fails = 0;
      outcomes.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_data.index)
          CFG_BASE_ADDRESS: arena_base = cfg_data.value;
          CFG_CAPACITY:     arena_cap = cfg_data.value[20:0];
          default: ;
        endcase
      end
      if (cmd_valid && cmd_ready) outcomes.push_back(apply_arena_op(cmd_data));
      if (rsp_valid && rsp_ready) begin
        if (outcomes.size() == 0) begin
          report($sformatf("unexpected result transaction, status %0d", rsp_data.status));
        end else begin
          want = outcomes.pop_front();
          if (rsp_data.status !== want.status)
            report($sformatf("status %0d, predicted %0d", rsp_data.status, want.status));
          if (rsp_data.block_address !== want.block_address)
            report($sformatf("block_address %h, predicted %h",
                             rsp_data.block_address, want.block_address));
          if (rsp_data.allocated_size !== want.allocated_size)
            report($sformatf("allocated_size %0d, predicted %0d",
                             rsp_data.allocated_size, want.allocated_size));
          if (rsp_data.used_bytes !== want.used_bytes)
            report($sformatf("used_bytes %0d, predicted %0d",
                             rsp_data.used_bytes, want.used_bytes));
        end
      end
    end
    pending = outcomes.size();
    live_count = nblocks;
    for (int k = 0; k < DEPTH; k++)
      live_addr[k] = (k < nblocks) ? 32'(block_addr(k)) : '0;
  end

endmodule

// ----- tb/tb_aligned_stack_allocator.sv -----
// Testbench top for the aligned stack allocator: stimulus, configuration phases and verdict.
module tb_aligned_stack_allocator;
  import asa_pkg::*;

  typedef enum {A_FIXED, A_TOP, A_LIVE, A_NEAR} addr_pick_t;

  logic              clk;
  logic              rst;
  int                send_idle;
  int                recv_idle;
  int                fails;
  int                pending;
  int                live_count;
  logic [15:0][31:0] live_addr;

  asa_stream_if #(.T(cmd_req_t)) cmd_if ();
  asa_stream_if #(.T(rsp_t))     rsp_if ();
  asa_stream_if #(.T(cfg_wr_t))  cfg_if ();

  aligned_stack_allocator dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if),
    .rsp (rsp_if),
    .cfg (cfg_if)
  );

  asa_arena_checker chk (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_if.valid),
    .cmd_ready  (cmd_if.ready),
    .cmd_data   (cmd_if.data),
    .rsp_valid  (rsp_if.valid),
    .rsp_ready  (rsp_if.ready),
    .rsp_data   (rsp_if.data),
    .cfg_valid  (cfg_if.valid),
    .cfg_ready  (cfg_if.ready),
    .cfg_data   (cfg_if.data),
    .fails      (fails),
    .pending    (pending),
    .live_count (live_count),
    .live_addr  (live_addr)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(64'd20 * 64'd500_000);
    $display("Mismatches found");
    $finish;
  end

  always @(posedge clk) rsp_if.ready <= ($urandom_range(99) >= recv_idle);

  function automatic cmd_req_t mk(kind_t k, logic [20:0] sz, logic [3:0] al, logic [31:0] a);
    cmd_req_t c;
    c.kind = k;
    c.request_size = sz;
    c.align_log2 = al;
    c.address = a;
    return c;
  endfunction

  // Address aimed at the live stack; near misses flip one bit of the top address.
  function automatic logic [31:0] pick_addr(addr_pick_t m, logic [31:0] fallback);
    logic [31:0] top;
    if (live_count == 0) return fallback;
    top = live_addr[live_count - 1];
    case (m)
      A_TOP:   return top;
      A_LIVE:  return live_addr[$urandom_range(live_count - 1)];
      default: return top ^ (32'd1 << $urandom_range(31));
    endcase
  endfunction

  // Called and left at a rising edge. Items that aim at live blocks are picked
  // at the falling edge, once the checker holds every earlier transaction.
  task automatic send(input cmd_req_t c, input addr_pick_t m);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle) gap++;
    if (m != A_FIXED && gap == 0) gap = 1;
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap - 1) @(posedge clk);
      @(negedge clk);
      if (m != A_FIXED) c.address = pick_addr(m, c.address);
      @(posedge clk);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.data <= c;
    do @(negedge clk); while (!cmd_if.ready);
    @(posedge clk);
  endtask

  task automatic wait_idle();
    cmd_if.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic set_arena(input logic [31:0] b, input logic [20:0] cp);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= '{index: CFG_BASE_ADDRESS, value: b};
    do @(negedge clk); while (!cfg_if.ready);
    @(posedge clk);
    cfg_if.data <= '{index: CFG_CAPACITY, value: 32'(cp)};
    do @(negedge clk); while (!cfg_if.ready);
    @(posedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    cmd_req_t    c;
    addr_pick_t  m;
    int          r;
    int          s;
    int          t;
    logic [31:0] bases  [6];
    logic [20:0] caps   [6];
    int          counts [6];

    rst = 1'b1;
    cmd_if.valid = 1'b0;
    cmd_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    rsp_if.ready = 1'b0;
    send_idle = 6;
    recv_idle = 82;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // null, empty stack and missing-address cases
    send(mk(K_QUERY, 21'd0, 4'd0, 32'd0), A_FIXED);
    send(mk(K_FREE, 21'h1FFFFF, 4'hF, 32'd0), A_FIXED);
    send(mk(K_FREE, 21'd0, 4'd0, 32'd4112), A_FIXED);
    send(mk(K_QUERY, 21'd0, 4'd0, 32'hFFFF_FFFF), A_FIXED);
    // zero-byte block, then an oversized one with clamped alignment
    send(mk(K_ALLOC, 21'd0, 4'd0, 32'd0), A_FIXED);
    send(mk(K_ALLOC, 21'd1048576, 4'd15, 32'd0), A_FIXED);
    for (int i = 1; i < 16; i++) send(mk(K_ALLOC, 21'(3 * i), 4'(i), 32'd0), A_FIXED);
    // record stack now full
    send(mk(K_ALLOC, 21'd8, 4'd3, 32'd0), A_FIXED);
    send(mk(K_QUERY, 21'd0, 4'd0, 32'd0), A_LIVE);
    send(mk(K_FREE, 21'd0, 4'd0, 32'd0), A_NEAR);
    send(mk(K_FREE, 21'd0, 4'd0, 32'd0), A_TOP);
    send(mk(K_RESET, '1, '1, '1), A_FIXED);

    bases = '{32'd0, 32'h0000_1235, 32'hFFFF_F000, 32'hFFFF_FFFF, $urandom(), BASE_RESET};
    caps = '{21'd1048576, 21'd300, 21'd1048576, 21'd0, 21'($urandom_range(1048576)),
             CAPACITY_RESET};
    counts = '{120, 120, 120, 40, 130, 120};

    for (int p = 0; p < 6; p++) begin
      wait_idle();
      if (p < 2) begin
        send_idle = 6;
        recv_idle = 82;
      end else if (p < 4) begin
        send_idle = 82;
        recv_idle = 6;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      set_arena(bases[p], caps[p]);
      repeat (counts[p]) begin
        r = $urandom_range(99);
        s = $urandom_range(99);
        t = $urandom_range(99);
        c.kind = K_ALLOC;
        c.address = $urandom();
        c.align_log2 = ($urandom_range(99) < 90) ? 4'($urandom_range(12))
                                                 : 4'($urandom_range(15, 13));
        if (t < 70)      c.request_size = 21'($urandom_range(64));
        else if (t < 90) c.request_size = 21'($urandom_range(4096));
        else if (t < 97) c.request_size = 21'($urandom_range(1048576));
        else             c.request_size = 21'($urandom());
        m = A_FIXED;
        if (r >= 45 && r < 72) begin
          c.kind = K_FREE;
          if (s < 70)      m = A_TOP;
          else if (s < 85) m = A_NEAR;
          if (s >= 95) c.address = '0;
        end else if (r >= 72 && r < 97) begin
          c.kind = K_QUERY;
          if (s < 60)      m = A_LIVE;
          else if (s < 75) m = A_NEAR;
          if (s >= 92) c.address = '0;
        end else if (r >= 97) begin
          c.kind = K_RESET;
        end
        send(c, m);
      end
    end

    wait_idle();
    repeat (40) @(posedge clk);
    if (fails == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/asa_pkg.sv
sv/asa_stream_if.sv
sv/asa_front.sv
sv/asa_cmd_queue.sv
sv/asa_back.sv
sv/aligned_stack_allocator.sv
tb/asa_arena_checker.sv
tb/tb_aligned_stack_allocator.sv
